// ===== rtl/cso_pkg.sv =====
// Package for the Coulomb sum about the origin block.
// Holds the shared state enum, the accumulator control struct and fixed widths.
// No dependencies.
package cso_pkg;

  localparam int AccBits    = 64;
  localparam int ChargeBits = 4;
  localparam int ProdBits   = AccBits + ChargeBits;

  localparam logic [AccBits-1:0] AccMax = {1'b0, {(AccBits-1){1'b1}}};
  localparam logic [AccBits-1:0] AccMin = {1'b1, {(AccBits-1){1'b0}}};

  typedef enum logic [2:0] {
    StIdle,
    StSquare,
    StRecip,
    StAccum,
    StFinal
  } cso_state_e;

  // Commands from the sequencer to the accumulator.
  typedef struct packed {
    logic origin_hit;
    logic term_load;
    logic acc_add;
    logic final_load;
  } cso_acc_ctrl_t;

endpackage

// ===== rtl/cso_ion_if.sv =====
// Valid/ready channel that carries one ion word.
// Depends on cso_pkg for the charge width.
interface cso_ion_if #(
  parameter int COORD_BITS = 8
);
  logic                                 valid;
  logic                                 ready;
  logic signed [COORD_BITS-1:0]         x_coord;
  logic signed [COORD_BITS-1:0]         y_coord;
  logic signed [COORD_BITS-1:0]         z_coord;
  logic signed [cso_pkg::ChargeBits-1:0] ion_charge;
  logic                                 last_ion;

  modport source (output valid, x_coord, y_coord, z_coord, ion_charge, last_ion,
                  input ready);
  modport sink (input valid, x_coord, y_coord, z_coord, ion_charge, last_ion,
                output ready);
endinterface

// ===== rtl/cso_res_if.sv =====
// Valid/ready channel that carries one result word.
// Depends on cso_pkg for the sum width.
interface cso_res_if;
  logic                              valid;
  logic                              ready;
  logic signed [cso_pkg::AccBits-1:0] madelung_sum;
  logic                              center_found;
  logic                              duplicate_center;
  logic                              sum_saturated;

  modport source (output valid, madelung_sum, center_found, duplicate_center,
                  sum_saturated, input ready);
  modport sink (input valid, madelung_sum, center_found, duplicate_center,
                sum_saturated, output ready);
endinterface

// ===== rtl/cso_dist_sq.sv =====
// Squared distance unit: one shared squarer walks over x, y and z in turn.
// No package dependencies.
module cso_dist_sq #(
  parameter int CoordBits = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [CoordBits-1:0]   x_i,
  input  logic [CoordBits-1:0]   y_i,
  input  logic [CoordBits-1:0]   z_i,
  output logic [2*CoordBits-1:0] d2_o,
  output logic                   done_o
);

  localparam int D2Bits = 2 * CoordBits;
  localparam logic [1:0] LastAxis = 2'd2;

  logic [2:0][CoordBits-1:0] mag_q, mag_d;
  logic [D2Bits-1:0]         d2_q, d2_d, sq;
  logic [1:0]                axis_q, axis_d;
  logic                      busy_q, busy_d;
  logic                      done_q, done_d;

  function automatic logic [CoordBits-1:0] abs_val(input logic [CoordBits-1:0] v);
    abs_val = v[CoordBits-1] ? (~v + 1'b1) : v;
  endfunction

  always_comb begin
    mag_d  = mag_q;
    d2_d   = d2_q;
    axis_d = axis_q;
    busy_d = busy_q;
    done_d = 1'b0;
    sq     = D2Bits'(mag_q[0]) * D2Bits'(mag_q[0]);
    if (start_i) begin
      mag_d[0] = abs_val(x_i);
      mag_d[1] = abs_val(y_i);
      mag_d[2] = abs_val(z_i);
      d2_d     = '0;
      axis_d   = '0;
      busy_d   = 1'b1;
    end else if (busy_q) begin
      // The magnitudes shift down so that the squarer always reads slot zero.
      d2_d     = d2_q + sq;
      mag_d[0] = mag_q[1];
      mag_d[1] = mag_q[2];
      axis_d   = axis_q + 1'b1;
      if (axis_q == LastAxis) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      axis_q <= axis_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    d2_q  <= d2_d;
  end

  assign d2_o   = d2_q;
  assign done_o = done_q;

endmodule

// ===== rtl/cso_recip_root.sv =====
// Reciprocal square root by digit recurrence: floor(2^F / sqrt(d2)) equals
// floor(sqrt(floor(2^(2F) / d2))), so a restoring divider hands two quotient
// bits per cycle to a square root recurrence. No package dependencies.
module cso_recip_root #(
  parameter int D2Bits   = 16,
  parameter int FracBits = 30
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [D2Bits-1:0]   d2_i,
  output logic [FracBits:0]   root_o,
  output logic                done_o
);

  localparam int RootBits = FracBits + 1;
  localparam int SremBits = FracBits + 2;
  localparam int CntBits  = $clog2(FracBits + 2);
  localparam logic [CntBits-1:0] Pairs = CntBits'(FracBits + 1);

  logic [D2Bits-1:0]   d2_q, d2_d;
  logic [D2Bits-1:0]   rem_q, rem_d, rem_mid, rem_lo;
  logic [1:0]          pair_q, pair_d;
  logic                pair_vld_q, pair_vld_d;
  logic [SremBits-1:0] srem_q, srem_d, srem_n;
  logic [RootBits-1:0] root_q, root_d;
  logic [CntBits-1:0]  left_q, left_d;
  logic                done_q, done_d;

  logic [D2Bits:0]     dv, t_hi, t_lo;
  logic                q_hi, q_lo, q_s;
  logic [SremBits+1:0] st, trial;

  always_comb begin
    // Two restoring division steps. The dividend 2^(2F) has its only set bit
    // in the low position of the first pair.
    dv      = {1'b0, d2_q};
    t_hi    = {rem_q, 1'b0};
    q_hi    = (t_hi >= dv);
    rem_mid = q_hi ? D2Bits'(t_hi - dv) : t_hi[D2Bits-1:0];
    t_lo    = {rem_mid, (left_q == Pairs)};
    q_lo    = (t_lo >= dv);
    rem_lo  = q_lo ? D2Bits'(t_lo - dv) : t_lo[D2Bits-1:0];

    // One square root step on the pair produced in the previous cycle.
    st     = {srem_q, pair_q};
    trial  = {1'b0, root_q, 2'b01};
    q_s    = (st >= trial);
    srem_n = q_s ? SremBits'(st - trial) : st[SremBits-1:0];

    d2_d       = d2_q;
    rem_d      = rem_q;
    pair_d     = pair_q;
    pair_vld_d = 1'b0;
    srem_d     = srem_q;
    root_d     = root_q;
    left_d     = left_q;
    done_d     = 1'b0;

    if (start_i) begin
      d2_d   = d2_i;
      rem_d  = '0;
      srem_d = '0;
      root_d = '0;
      left_d = Pairs;
    end else begin
      if (left_q != '0) begin
        rem_d      = rem_lo;
        pair_d     = {q_hi, q_lo};
        pair_vld_d = 1'b1;
        left_d     = left_q - 1'b1;
      end
      if (pair_vld_q) begin
        srem_d = srem_n;
        root_d = {root_q[RootBits-2:0], q_s};
        done_d = (left_q == '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q     <= '0;
      pair_vld_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      left_q     <= left_d;
      pair_vld_q <= pair_vld_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d2_q   <= d2_d;
    rem_q  <= rem_d;
    pair_q <= pair_d;
    srem_q <= srem_d;
    root_q <= root_d;
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

// ===== rtl/cso_accum.sv =====
// Accumulator: center tracking, saturating sum of charge over distance and the
// final saturated product with the center charge. Depends on cso_pkg.
module cso_accum #(
  parameter int FracBits = 30
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  cso_pkg::cso_acc_ctrl_t                ctrl_i,
  input  logic signed [cso_pkg::ChargeBits-1:0] charge_i,
  input  logic [FracBits:0]                     root_i,
  output logic signed [cso_pkg::AccBits-1:0]    sum_o,
  output logic                                  center_found_o,
  output logic                                  duplicate_o,
  output logic                                  saturated_o
);

  localparam int TermBits = FracBits + 1 + cso_pkg::ChargeBits;
  localparam int SumBits  = cso_pkg::AccBits + 1;
  localparam int HiBits   = cso_pkg::ProdBits - cso_pkg::AccBits + 1;

  logic signed [cso_pkg::AccBits-1:0]    acc_q, acc_d;
  logic signed [cso_pkg::ChargeBits-1:0] center_q, center_d;
  logic                                  seen_q, seen_d;
  logic                                  dup_q, dup_d;
  logic                                  sat_q, sat_d;
  logic signed [TermBits-1:0]            term_q, term_d;

  logic signed [SumBits-1:0]             sum_ext;
  logic                                  add_ovf;
  logic signed [cso_pkg::ProdBits-1:0]   prod;
  logic [HiBits-1:0]                     prod_hi;
  logic                                  prod_fits;

  always_comb begin
    sum_ext = SumBits'(acc_q) + SumBits'(term_q);
    add_ovf = (sum_ext[SumBits-1] != sum_ext[SumBits-2]);

    acc_d    = acc_q;
    center_d = center_q;
    seen_d   = seen_q;
    dup_d    = dup_q;
    sat_d    = sat_q;
    term_d   = term_q;

    if (ctrl_i.final_load) begin
      acc_d    = '0;
      center_d = '0;
      seen_d   = 1'b0;
      dup_d    = 1'b0;
      sat_d    = 1'b0;
    end else begin
      if (ctrl_i.origin_hit) begin
        // Only the first ion at the origin becomes the center.
        if (seen_q) begin
          dup_d = 1'b1;
        end else begin
          seen_d   = 1'b1;
          center_d = charge_i;
        end
      end
      if (ctrl_i.term_load) begin
        term_d = TermBits'(charge_i) * TermBits'(signed'({1'b0, root_i}));
      end
      if (ctrl_i.acc_add) begin
        if (add_ovf) begin
          acc_d = sum_ext[SumBits-1] ? cso_pkg::AccMin : cso_pkg::AccMax;
          sat_d = 1'b1;
        end else begin
          acc_d = sum_ext[cso_pkg::AccBits-1:0];
        end
      end
    end
  end

  // The product fits when its top bits are all copies of the result sign.
  always_comb begin
    prod      = cso_pkg::ProdBits'(acc_q) * cso_pkg::ProdBits'(center_q);
    prod_hi   = prod[cso_pkg::ProdBits-1:cso_pkg::AccBits-1];
    prod_fits = (&prod_hi) | ~(|prod_hi);
    if (prod_fits) begin
      sum_o = prod[cso_pkg::AccBits-1:0];
    end else begin
      sum_o = prod[cso_pkg::ProdBits-1] ? cso_pkg::AccMin : cso_pkg::AccMax;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      center_q <= '0;
      seen_q   <= 1'b0;
      dup_q    <= 1'b0;
      sat_q    <= 1'b0;
    end else begin
      acc_q    <= acc_d;
      center_q <= center_d;
      seen_q   <= seen_d;
      dup_q    <= dup_d;
      sat_q    <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    term_q <= term_d;
  end

  assign center_found_o = seen_q;
  assign duplicate_o    = dup_q;
  assign saturated_o    = sat_q | ~prod_fits;

endmodule

// ===== rtl/coulomb_sum_about_origin.sv =====
// Coulomb sum about the origin: sequencer, result register and unit wiring.
// Depends on cso_pkg, cso_ion_if, cso_res_if, cso_dist_sq, cso_recip_root, cso_accum.
//
//   channel  direction  word                                    handshake
//   ion_i    in         x, y, z coordinates, charge, last mark   valid/ready
//   res_o    out        sum, center, duplicate, saturated flags  valid/ready
//
// An ion off the origin passes through the shared squarer, the divide and square
// root recurrence, then term and accumulate, before the next acceptance. An ion at
// the origin is handled in the idle state itself. A last ion then passes through
// the final state to write the result word. Reset is asynchronous and clears the
// running sum and flags but not the held result word; no clearing pass follows.
// A result word waits in its own register, so later ions are taken while it is
// held; only the next last ion stalls until that register has been read.
module coulomb_sum_about_origin #(
  parameter int COORD_BITS = 8,
  parameter int FRAC_BITS  = 30
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  cso_ion_if.sink  ion_i,
  cso_res_if.source res_o
);

  localparam int D2Bits = 2 * COORD_BITS;

  cso_pkg::cso_state_e                   state_q, state_d;
  cso_pkg::cso_acc_ctrl_t                ctrl;
  logic signed [cso_pkg::ChargeBits-1:0] charge_q, charge_d, acc_charge;
  logic                                  last_q, last_d;
  logic                                  accept, origin;
  logic                                  sq_start, sq_done, rr_start, rr_done;
  logic [D2Bits-1:0]                     d2;
  logic [FRAC_BITS:0]                    root;

  logic signed [cso_pkg::AccBits-1:0]    fin_sum;
  logic                                  fin_center, fin_dup, fin_sat;
  logic                                  out_load, out_free;
  logic                                  out_vld_q, out_vld_d;
  logic signed [cso_pkg::AccBits-1:0]    out_sum_q;
  logic                                  out_center_q, out_dup_q, out_sat_q;

  assign ion_i.ready = (state_q == cso_pkg::StIdle);
  assign accept      = ion_i.valid && ion_i.ready;
  assign origin      = (ion_i.x_coord == '0) && (ion_i.y_coord == '0) &&
                       (ion_i.z_coord == '0);
  assign out_free    = !out_vld_q || res_o.ready;

  // The center charge comes straight from the input word; terms use the copy.
  assign acc_charge = (state_q == cso_pkg::StIdle) ? ion_i.ion_charge : charge_q;

  always_comb begin
    state_d  = state_q;
    charge_d = charge_q;
    last_d   = last_q;
    ctrl     = '0;
    sq_start = 1'b0;
    rr_start = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      cso_pkg::StIdle: begin
        if (accept) begin
          charge_d = ion_i.ion_charge;
          last_d   = ion_i.last_ion;
          if (origin) begin
            ctrl.origin_hit = 1'b1;
            if (ion_i.last_ion) begin
              state_d = cso_pkg::StFinal;
            end
          end else begin
            sq_start = 1'b1;
            state_d  = cso_pkg::StSquare;
          end
        end
      end
      cso_pkg::StSquare: begin
        if (sq_done) begin
          rr_start = 1'b1;
          state_d  = cso_pkg::StRecip;
        end
      end
      cso_pkg::StRecip: begin
        if (rr_done) begin
          ctrl.term_load = 1'b1;
          state_d        = cso_pkg::StAccum;
        end
      end
      cso_pkg::StAccum: begin
        ctrl.acc_add = 1'b1;
        state_d      = last_q ? cso_pkg::StFinal : cso_pkg::StIdle;
      end
      cso_pkg::StFinal: begin
        if (out_free) begin
          ctrl.final_load = 1'b1;
          out_load        = 1'b1;
          state_d         = cso_pkg::StIdle;
        end
      end
      default: begin
        state_d = cso_pkg::StIdle;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (res_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= cso_pkg::StIdle;
      last_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      last_q    <= last_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    charge_q <= charge_d;
    if (out_load) begin
      out_sum_q    <= fin_sum;
      out_center_q <= fin_center;
      out_dup_q    <= fin_dup;
      out_sat_q    <= fin_sat;
    end
  end

  cso_dist_sq #(
    .CoordBits (COORD_BITS)
  ) u_dist_sq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .x_i     (ion_i.x_coord),
    .y_i     (ion_i.y_coord),
    .z_i     (ion_i.z_coord),
    .d2_o    (d2),
    .done_o  (sq_done)
  );

  cso_recip_root #(
    .D2Bits   (D2Bits),
    .FracBits (FRAC_BITS)
  ) u_recip_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rr_start),
    .d2_i    (d2),
    .root_o  (root),
    .done_o  (rr_done)
  );

  cso_accum #(
    .FracBits (FRAC_BITS)
  ) u_accum (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .charge_i       (acc_charge),
    .root_i         (root),
    .sum_o          (fin_sum),
    .center_found_o (fin_center),
    .duplicate_o    (fin_dup),
    .saturated_o    (fin_sat)
  );

  assign res_o.valid            = out_vld_q;
  assign res_o.madelung_sum     = out_sum_q;
  assign res_o.center_found     = out_center_q;
  assign res_o.duplicate_center = out_dup_q;
  assign res_o.sum_saturated    = out_sat_q;

endmodule

// ===== test/coulomb_sum_about_origin_tb.sv =====
// Testbench for coulomb_sum_about_origin: random and directed ion sets, with a predicted sum per set.
// A scoreboard class predicts each result word, and the DUT output is checked against it.
// Depends on cso_pkg, cso_ion_if, cso_res_if and the RTL top level.
module coulomb_sum_about_origin_tb;

  localparam int CoordBits    = 8;
  localparam int FracBits     = 30;
  localparam int IonTarget    = 1650;
  localparam int SettleCycles = FracBits + 30;
  localparam int CycleLimit   = 1_000_000;

  localparam int AccBits    = cso_pkg::AccBits;
  localparam int ChargeBits = cso_pkg::ChargeBits;
  localparam int ProdBits   = cso_pkg::ProdBits;

  localparam logic [AccBits-1:0] AccMax = cso_pkg::AccMax;
  localparam logic [AccBits-1:0] AccMin = cso_pkg::AccMin;

  typedef struct {
    logic signed [CoordBits-1:0]  x;
    logic signed [CoordBits-1:0]  y;
    logic signed [CoordBits-1:0]  z;
    logic signed [ChargeBits-1:0] q;
    logic                         last;
  } ion_t;

  typedef struct {
    logic signed [AccBits-1:0] sum;
    logic                      center;
    logic                      dup;
    logic                      sat;
  } madelung_word_t;

  class madelung_tracker;
    logic signed [AccBits-1:0]    acc;
    logic signed [ChargeBits-1:0] center_q;
    logic                         center_seen;
    logic                         dup_seen;
    logic                         sat_seen;
    madelung_word_t               pending[$];
    int                           errors;

    function new();
      clear();
      errors = 0;
    endfunction

    function void clear();
      acc         = '0;
      center_q    = '0;
      center_seen = 1'b0;
      dup_seen    = 1'b0;
      sat_seen    = 1'b0;
    endfunction

    // Largest r with r*r*d2 <= 2^(2*FracBits), found one bit at a time.
    function logic [FracBits+1:0] inv_root(int unsigned d2);
      logic [FracBits+1:0] r;
      logic [FracBits+1:0] t;
      logic [127:0]        tt;
      r = '0;
      for (int b = FracBits; b >= 0; b--) begin
        t  = r | ((FracBits+2)'(1) << b);
        tt = 128'(t);
        if (tt * tt * 128'(d2) <= (128'd1 << (2 * FracBits))) r = t;
      end
      return r;
    endfunction

    function void add_term(longint term);
      logic signed [AccBits:0] s;
      s = {acc[AccBits-1], acc} + {term[63], term};
      if (s[AccBits] != s[AccBits-1]) begin
        sat_seen = 1'b1;
        acc      = s[AccBits] ? AccMin : AccMax;
      end else begin
        acc = s[AccBits-1:0];
      end
    endfunction

    function logic signed [AccBits-1:0] scaled_sum();
      logic signed [ProdBits-1:0] p;
      p = $signed({{(ProdBits-AccBits){acc[AccBits-1]}}, acc}) *
          $signed({{(ProdBits-ChargeBits){center_q[ChargeBits-1]}}, center_q});
      // The product fits only when every bit above the sign agrees with it.
      if (p[ProdBits-1:AccBits-1] != {(ProdBits-AccBits+1){p[ProdBits-1]}}) begin
        sat_seen = 1'b1;
        return p[ProdBits-1] ? AccMin : AccMax;
      end
      return p[AccBits-1:0];
    endfunction

    function void take_ion(ion_t w);
      int             xi;
      int             yi;
      int             zi;
      madelung_word_t e;
      xi = w.x;
      yi = w.y;
      zi = w.z;
      if (xi == 0 && yi == 0 && zi == 0) begin
        if (center_seen) begin
          dup_seen = 1'b1;
        end else begin
          center_seen = 1'b1;
          center_q    = w.q;
        end
      end else begin
        add_term(longint'(w.q) * longint'(inv_root(xi * xi + yi * yi + zi * zi)));
      end
      if (w.last) begin
        e.sum    = scaled_sum();
        e.center = center_seen;
        e.dup    = dup_seen;
        e.sat    = sat_seen;
        pending  = {pending, e};
        clear();
      end
    endfunction

    function void report(string field, logic signed [63:0] exp_v, logic signed [63:0] got_v);
      errors++;
      $display("%0t: %s expected %0d got %0d", $time, field, exp_v, got_v);
    endfunction

    function void check_sum(madelung_word_t got);
      madelung_word_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result word with none expected, sum %0d", $time, got.sum);
        return;
      end
      e = pending.pop_front();
      if (got.sum !== e.sum) report("madelung_sum", e.sum, got.sum);
      if (got.center !== e.center) report("center_found", e.center, got.center);
      if (got.dup !== e.dup) report("duplicate_center", e.dup, got.dup);
      if (got.sat !== e.sat) report("sum_saturated", e.sat, got.sat);
    endfunction

    function int pending_count();
      return pending.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   steady;
  int   ions_sent;

  madelung_tracker board = new();

  cso_ion_if #(.COORD_BITS(CoordBits)) ion_if ();
  cso_res_if res_if ();

  coulomb_sum_about_origin #(
    .COORD_BITS(CoordBits),
    .FRAC_BITS (FracBits)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ion_i (ion_if),
    .res_o (res_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic ion_t mk(int x, int y, int z, int q, bit last);
    ion_t w;
    w.x    = CoordBits'(x);
    w.y    = CoordBits'(y);
    w.z    = CoordBits'(z);
    w.q    = ChargeBits'(q);
    w.last = last;
    return w;
  endfunction

  // Off-origin ion: either within three of the origin with unit charge of random sign, or anywhere in range.
  function automatic ion_t rand_ion(bit full);
    ion_t w;
    do begin
      if (full) begin
        w = mk($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
               $urandom_range(0, 15), 1'b0);
      end else begin
        w = mk(int'($urandom_range(0, 6)) - 3, int'($urandom_range(0, 6)) - 3,
               int'($urandom_range(0, 6)) - 3, $urandom_range(0, 1) ? 1 : -1, 1'b0);
      end
    end while (w.x == 0 && w.y == 0 && w.z == 0);
    return w;
  endfunction

  task automatic send_ion(ion_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      ion_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    ion_if.valid      <= 1'b1;
    ion_if.x_coord    <= w.x;
    ion_if.y_coord    <= w.y;
    ion_if.z_coord    <= w.z;
    ion_if.ion_charge <= w.q;
    ion_if.last_ion   <= w.last;
    do @(posedge clk_i); while (!ion_if.ready);
    board.take_ion(w);
    ions_sent++;
  endtask

  task automatic wait_for_results();
    ion_if.valid <= 1'b0;
    do @(posedge clk_i); while (board.pending_count() != 0);
  endtask

  task automatic send_set(int n, int centers, bit full);
    ion_t set_q[$];
    ion_t c;
    for (int i = 0; i < n; i++) set_q = {set_q, rand_ion(full)};
    for (int k = 0; k < centers; k++) begin
      c = mk(0, 0, 0, full ? $urandom_range(0, 15) : ($urandom_range(0, 1) ? 1 : -1), 1'b0);
      set_q.insert($urandom_range(0, set_q.size()), c);
    end
    set_q[set_q.size()-1].last = 1'b1;
    foreach (set_q[i]) send_ion(set_q[i]);
  endtask

  // Result side: random stalls on ready, checks every accepted word.
  initial begin
    int             stall_left;
    madelung_word_t got;
    stall_left   = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) begin
        got.sum    = res_if.madelung_sum;
        got.center = res_if.center_found;
        got.dup    = res_if.duplicate_center;
        got.sat    = res_if.sum_saturated;
        board.check_sum(got);
      end
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin
    int set_no;
    int kind;
    int n;
    int centers;
    bit full;
    set_no            = 0;
    ions_sent         = 0;
    steady            = 1'b0;
    rst_ni            <= 1'b0;
    ion_if.valid      <= 1'b0;
    ion_if.x_coord    <= '0;
    ion_if.y_coord    <= '0;
    ion_if.z_coord    <= '0;
    ion_if.ion_charge <= '0;
    ion_if.last_ion   <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Center as the only and last ion, then a set with no center at all.
    send_ion(mk(0, 0, 0, -8, 1'b1));
    send_ion(mk(127, -128, 1, 7, 1'b1));
    // Ions before the center, corners of the range, a duplicate center and zero charge.
    send_ion(mk(1, 0, 0, 7, 1'b0));
    send_ion(mk(0, 0, 0, -8, 1'b0));
    send_ion(mk(-128, -128, -128, -1, 1'b0));
    send_ion(mk(127, 127, 127, 7, 1'b0));
    send_ion(mk(0, 0, 0, 3, 1'b0));
    send_ion(mk(-128, 127, 0, -8, 1'b0));
    send_ion(mk(0, -1, 0, 0, 1'b0));
    send_ion(mk(0, 0, 1, -8, 1'b1));
    // Rock salt neighbors around a unit center.
    send_ion(mk(0, 0, 0, 1, 1'b0));
    send_ion(mk(1, 0, 0, -1, 1'b0));
    send_ion(mk(-1, 0, 0, -1, 1'b0));
    send_ion(mk(0, 1, 1, 1, 1'b0));
    send_ion(mk(1, 1, 1, -1, 1'b0));
    send_ion(mk(0, 0, -1, -1, 1'b1));
    // A duplicate center as the last ion, then a set with its center between two ions.
    send_ion(mk(0, 0, 0, 7, 1'b0));
    send_ion(mk(1, 1, 1, -8, 1'b0));
    send_ion(mk(0, 0, 0, -8, 1'b1));
    send_ion(mk(2, -3, 0, 5, 1'b0));
    send_ion(mk(0, 0, 0, -1, 1'b0));
    send_ion(mk(-7, 4, -2, -3, 1'b1));
    wait_for_results();

    while (ions_sent < IonTarget) begin
      set_no++;
      steady  = (set_no % 50) >= 40;
      kind    = $urandom_range(0, 99);
      centers = (kind < 70) ? 1 : (kind < 85) ? 0 : $urandom_range(2, 3);
      n       = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 12);
      if (n == 0 && centers == 0) n = 1;
      full = ($urandom_range(0, 3) == 0);
      send_set(n, centers, full);
      if ($urandom_range(0, 29) == 0) wait_for_results();
    end

    wait_for_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/cso_pkg.sv
rtl/cso_ion_if.sv
rtl/cso_res_if.sv
rtl/cso_dist_sq.sv
rtl/cso_recip_root.sv
rtl/cso_accum.sv
rtl/coulomb_sum_about_origin.sv
test/coulomb_sum_about_origin_tb.sv
